// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/fsfl_pkg.sv -----
// ----------------------------------------------------------------------------
// fsfl_pkg
// Types and codes for the four-state flop/latch evaluator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fsfl_pkg;

	typedef logic [1:0] level_t;

	localparam level_t LV_ZERO  = 2'd0;
	localparam level_t LV_ONE   = 2'd1;
	localparam level_t LV_X     = 2'd2;
	localparam level_t LV_UNDEF = 2'd3;

	typedef logic [1:0] clr_mode_t;

	localparam clr_mode_t CLR_NONE     = 2'd0;
	localparam clr_mode_t CLR_ACT_LOW  = 2'd1;
	localparam clr_mode_t CLR_ACT_HIGH = 2'd2;

	localparam int unsigned ADDR_W = 5;
	localparam int unsigned DATA_W = 32;

	typedef enum logic [2:0] {
		REG_IS_FLIP_FLOP = 3'd0,
		REG_ASYNC_CLEAR  = 3'd1,
		REG_FALLING_EDGE = 3'd2,
		REG_HAS_ENABLE   = 3'd3,
		REG_CLEAR_MODE   = 3'd4,
		REG_HAS_SET      = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic      is_flip_flop;
		logic      async_clear;
		logic      falling_edge;
		logic      has_enable;
		clr_mode_t clear_mode;
		logic      has_set;
	} cfg_t;

	typedef struct packed {
		level_t data_level;
		level_t clock_level;
		level_t enable_level;
		level_t clear_level;
		level_t set_level;
	} stim_t;

endpackage

// ----- hdl/fsfl_stim_if.sv -----
// ----------------------------------------------------------------------------
// fsfl_stim_if
// Input item channel: pin levels of one evaluation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface fsfl_stim_if;
	logic            valid;
	logic            ready;
	fsfl_pkg::level_t data_level;
	fsfl_pkg::level_t clock_level;
	fsfl_pkg::level_t enable_level;
	fsfl_pkg::level_t clear_level;
	fsfl_pkg::level_t set_level;

	modport source (
		output valid, data_level, clock_level, enable_level, clear_level, set_level,
		input  ready
	);
	modport sink (
		input  valid, data_level, clock_level, enable_level, clear_level, set_level,
		output ready
	);
endinterface

// ----- hdl/fsfl_result_if.sv -----
// ----------------------------------------------------------------------------
// fsfl_result_if
// Result item channel: new Q level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface fsfl_result_if;
	logic             valid;
	logic             ready;
	fsfl_pkg::level_t q_level;

	modport source (
		output valid, q_level,
		input  ready
	);
	modport sink (
		input  valid, q_level,
		output ready
	);
endinterface

// ----- hdl/four_state_flop_latch_eval.sv -----
// ----------------------------------------------------------------------------
// four_state_flop_latch_eval
// Four-state flip-flop / latch evaluator: one new Q per pin-level item.
// ----------------------------------------------------------------------------
//  channel   dir  handshake            payload
//  stim      in   valid/ready          data, clock, enable, clear, set levels
//  result    out  valid/ready          q_level
//  apb       in   psel/penable/pready  six cell configuration registers
//
//  Accept to result: input register, then result register.
//  One item per cycle sustained while result.ready stays high; the Q/last-clock
//  update is one level of logic between the input register and the result register.
//  Reset gives a flip-flop with Q undefined and last clock X.
//  A stalled result holds the result register; one more item waits in the
//  input register before stim.ready drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module four_state_flop_latch_eval import fsfl_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	fsfl_stim_if.sink         stim,
	fsfl_result_if.source     result
);

	cfg_t   cfg;
	stim_t  stim_s1;
	logic   valid_s1;
	level_t q_s2;
	logic   valid_s2;
	level_t q_q;
	level_t last_clk_q;
	level_t q_next;
	level_t last_clk_next;
	logic   adv;

	fsfl_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	fsfl_next_q u_next (
		.cfg           (cfg),
		.stim          (stim_s1),
		.q_cur         (q_q),
		.last_clk      (last_clk_q),
		.q_next        (q_next),
		.last_clk_next (last_clk_next)
	);

	assign adv        = valid_s1 & (~valid_s2 | result.ready);
	assign stim.ready = ~valid_s1 | adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stim.ready) begin
			valid_s1 <= stim.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (stim.ready && stim.valid) begin
			stim_s1.data_level   <= stim.data_level;
			stim_s1.clock_level  <= stim.clock_level;
			stim_s1.enable_level <= stim.enable_level;
			stim_s1.clear_level  <= stim.clear_level;
			stim_s1.set_level    <= stim.set_level;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2   <= 1'b0;
			q_q        <= LV_UNDEF;
			last_clk_q <= LV_X;
		end else begin
			if (adv) begin
				valid_s2   <= 1'b1;
				q_q        <= q_next;
				last_clk_q <= last_clk_next;
			end else if (result.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			q_s2 <= q_next;
		end
	end

	assign result.valid   = valid_s2;
	assign result.q_level = q_s2;

	`ASSERT_NOW(a_no_undef_out, valid_s2, q_s2 != LV_UNDEF, "result Q is undefined")
	`ASSERT_NEXT(a_q_holds, !adv, $stable(q_q) && $stable(last_clk_q), "cell state moved without an item")
	`ASSERT_NEXT(a_latch_clk, adv && !cfg.is_flip_flop, $stable(last_clk_q), "latch changed last clock")
	`ASSERT_NEXT(a_stall_hold, valid_s1 && valid_s2 && !result.ready, valid_s1 && $stable(stim_s1), "waiting item lost")

endmodule

// ----- hdl/fsfl_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// fsfl_cfg_regs
// APB-style configuration registers for the cell type and its pins.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fsfl_cfg_regs import fsfl_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en  = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.is_flip_flop <= 1'b1;
			cfg_q.async_clear  <= 1'b0;
			cfg_q.falling_edge <= 1'b0;
			cfg_q.has_enable   <= 1'b0;
			cfg_q.clear_mode   <= CLR_NONE;
			cfg_q.has_set      <= 1'b0;
		end else if (wr_en) begin
			case (idx)
				REG_IS_FLIP_FLOP: cfg_q.is_flip_flop <= pwdata[0];
				REG_ASYNC_CLEAR:  cfg_q.async_clear  <= pwdata[0];
				REG_FALLING_EDGE: cfg_q.falling_edge <= pwdata[0];
				REG_HAS_ENABLE:   cfg_q.has_enable   <= pwdata[0];
				REG_CLEAR_MODE:   cfg_q.clear_mode   <= pwdata[1:0];
				REG_HAS_SET:      cfg_q.has_set      <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			REG_IS_FLIP_FLOP: prdata[0]   = cfg_q.is_flip_flop;
			REG_ASYNC_CLEAR:  prdata[0]   = cfg_q.async_clear;
			REG_FALLING_EDGE: prdata[0]   = cfg_q.falling_edge;
			REG_HAS_ENABLE:   prdata[0]   = cfg_q.has_enable;
			REG_CLEAR_MODE:   prdata[1:0] = cfg_q.clear_mode;
			REG_HAS_SET:      prdata[0]   = cfg_q.has_set;
			default: ;
		endcase
	end

endmodule

// ----- hdl/fsfl_next_q.sv -----
// ----------------------------------------------------------------------------
// fsfl_next_q
// Next-state logic of the cell: clear, set, edge detect and data capture.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fsfl_next_q import fsfl_pkg::*; (
	input  cfg_t   cfg,
	input  stim_t  stim,
	input  level_t q_cur,
	input  level_t last_clk,
	output level_t q_next,
	output level_t last_clk_next
);

	typedef enum logic [1:0] {
		EFF_NONE  = 2'd0,
		EFF_FORCE = 2'd1,
		EFF_X     = 2'd2
	} effect_t;

	effect_t clr_eff;
	effect_t set_eff;
	effect_t ctl_clr;
	logic    enabled;
	logic    tick;
	level_t  cap_d;
	level_t  q_w;
	logic    written;

	always_comb begin
		case (cfg.clear_mode)
			CLR_ACT_HIGH:
				clr_eff = (stim.clear_level == LV_ONE)  ? EFF_FORCE :
				          (stim.clear_level == LV_ZERO) ? EFF_NONE : EFF_X;
			CLR_ACT_LOW:
				clr_eff = (stim.clear_level == LV_ZERO) ? EFF_FORCE :
				          (stim.clear_level == LV_ONE)  ? EFF_NONE : EFF_X;
			default: clr_eff = EFF_NONE;
		endcase
	end

	always_comb begin
		if (!cfg.has_set) begin
			set_eff = EFF_NONE;
		end else begin
			set_eff = (stim.set_level == LV_ONE)  ? EFF_FORCE :
			          (stim.set_level == LV_ZERO) ? EFF_NONE : EFF_X;
		end
	end

	assign enabled = cfg.has_enable ? (stim.enable_level == LV_ONE) : 1'b1;
	assign tick    = cfg.falling_edge ?
	                 (last_clk == LV_ONE  && stim.clock_level == LV_ZERO) :
	                 (last_clk == LV_ZERO && stim.clock_level == LV_ONE);
	assign cap_d   = (stim.data_level == LV_ZERO || stim.data_level == LV_ONE) ?
	                 stim.data_level : LV_X;
	assign ctl_clr = (cfg.is_flip_flop && cfg.async_clear) ? EFF_NONE : clr_eff;

	always_comb begin
		q_w     = q_cur;
		written = 1'b0;
		if (cfg.is_flip_flop && cfg.async_clear && clr_eff != EFF_NONE) begin
			q_w     = (clr_eff == EFF_FORCE) ? LV_ZERO : LV_X;
			written = 1'b1;
		end else if (!cfg.is_flip_flop || tick) begin
			if (ctl_clr == EFF_FORCE) begin
				q_w     = LV_ZERO;
				written = 1'b1;
			end else if (ctl_clr == EFF_X) begin
				q_w     = LV_X;
				written = 1'b1;
			end else if (set_eff == EFF_FORCE) begin
				q_w     = LV_ONE;
				written = 1'b1;
			end else if (set_eff == EFF_X) begin
				q_w     = LV_X;
				written = 1'b1;
			end else if (cfg.is_flip_flop ? enabled : (stim.clock_level == LV_ONE)) begin
				q_w     = cap_d;
				written = 1'b1;
			end
		end
	end

	assign q_next        = (!written && q_w == LV_UNDEF) ? LV_X : q_w;
	assign last_clk_next = cfg.is_flip_flop ? stim.clock_level : last_clk;

endmodule

// ----- bench/tb_four_state_flop_latch_eval.sv -----
// ----------------------------------------------------------------------------
// tb_four_state_flop_latch_eval
// Self-checking bench for the four-state flop/latch evaluator. Pin-level items
// go in through the stim channel. A cell model in the bench tracks Q and the
// last clock level, and checks each new Q in order. Cell settings change over
// the APB port between phases: latch and flop, both edges, sync and async
// clear, set, enable, and the unused clear mode. Both channels idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_four_state_flop_latch_eval;
	import fsfl_pkg::*;

	localparam level_t    PIN_Z       = LV_UNDEF;
	localparam clr_mode_t CLR_UNUSED  = CLR_ACT_LOW | CLR_ACT_HIGH;
	localparam int        NUM_PHASES  = 10;
	localparam int        PHASE_ITEMS = 65;
	localparam int        HOLD_CYCLES = 50;
	localparam int        STALL_LIMIT = 1000;

	typedef enum logic [1:0] {PIN_IDLE, PIN_ACTIVE, PIN_UNKNOWN} pin_force_t;

	class q_level_board;
		cfg_t   cur_cfg;
		level_t q_held;
		level_t clock_seen;
		level_t q_due[$];
		int     n_items;
		int     n_checked;
		int     n_errors;

		function new();
			cur_cfg = '{is_flip_flop: 1'b1, async_clear: 1'b0, falling_edge: 1'b0,
				has_enable: 1'b0, clear_mode: CLR_NONE, has_set: 1'b0};
			q_held = LV_UNDEF;
			clock_seen = LV_X;
		endfunction

		function void set_reg(reg_idx_t idx, logic [DATA_W-1:0] val);
			case (idx)
				REG_IS_FLIP_FLOP: cur_cfg.is_flip_flop = val[0];
				REG_ASYNC_CLEAR:  cur_cfg.async_clear  = val[0];
				REG_FALLING_EDGE: cur_cfg.falling_edge = val[0];
				REG_HAS_ENABLE:   cur_cfg.has_enable   = val[0];
				REG_CLEAR_MODE:   cur_cfg.clear_mode   = val[1:0];
				REG_HAS_SET:      cur_cfg.has_set      = val[0];
				default: ;
			endcase
		endfunction

		function pin_force_t clear_force(level_t v);
			case (cur_cfg.clear_mode)
				CLR_ACT_HIGH: return v == LV_ONE ? PIN_ACTIVE : (v == LV_ZERO ? PIN_IDLE : PIN_UNKNOWN);
				CLR_ACT_LOW:  return v == LV_ZERO ? PIN_ACTIVE : (v == LV_ONE ? PIN_IDLE : PIN_UNKNOWN);
				default:      return PIN_IDLE;
			endcase
		endfunction

		function pin_force_t set_force(level_t v);
			if (!cur_cfg.has_set)
				return PIN_IDLE;
			return v == LV_ONE ? PIN_ACTIVE : (v == LV_ZERO ? PIN_IDLE : PIN_UNKNOWN);
		endfunction

		// clear first, then set; returns 1 when Q was forced
		function bit force_q(stim_t s, bit use_clear, inout level_t q);
			pin_force_t c;
			pin_force_t st;
			c = use_clear ? clear_force(s.clear_level) : PIN_IDLE;
			if (c != PIN_IDLE) begin
				q = (c == PIN_ACTIVE) ? LV_ZERO : LV_X;
				return 1'b1;
			end
			st = set_force(s.set_level);
			if (st != PIN_IDLE) begin
				q = (st == PIN_ACTIVE) ? LV_ONE : LV_X;
				return 1'b1;
			end
			return 1'b0;
		endfunction

		function level_t captured(level_t d);
			return (d == LV_ZERO || d == LV_ONE) ? d : LV_X;
		endfunction

		function void note_pins(stim_t s);
			level_t     q;
			level_t     prev;
			bit         written;
			bit         enabled;
			bit         tick;
			pin_force_t c;
			q = q_held;
			written = 1'b0;
			n_items++;
			if (cur_cfg.is_flip_flop) begin
				enabled = cur_cfg.has_enable ? (s.enable_level == LV_ONE) : 1'b1;
				prev = clock_seen;
				clock_seen = s.clock_level;
				if (cur_cfg.async_clear) begin
					c = clear_force(s.clear_level);
					if (c != PIN_IDLE) begin
						q = (c == PIN_ACTIVE) ? LV_ZERO : LV_X;
						written = 1'b1;
					end
				end
				if (!written) begin
					tick = cur_cfg.falling_edge ? (prev == LV_ONE && s.clock_level == LV_ZERO)
						: (prev == LV_ZERO && s.clock_level == LV_ONE);
					if (tick) begin
						written = force_q(s, !cur_cfg.async_clear, q);
						if (!written && enabled) begin
							q = captured(s.data_level);
							written = 1'b1;
						end
					end
				end
			end else begin
				written = force_q(s, 1'b1, q);
				if (!written && s.clock_level == LV_ONE) begin
					q = captured(s.data_level);
					written = 1'b1;
				end
			end
			if (!written && q == LV_UNDEF)
				q = LV_X;
			q_held = q;
			q_due = {q_due, q};
		endfunction

		function void check_q(level_t got);
			level_t want;
			if (q_due.size() == 0) begin
				n_errors++;
				$display("%0t: q_level with nothing due, expected none, actual %0d", $time, got);
				return;
			end
			want = q_due.pop_front();
			n_checked++;
			if (got !== want) begin
				n_errors++;
				$display("%0t: q_level mismatch, expected %0d, actual %0d", $time, want, got);
			end
		endfunction

		function int pending();
			return q_due.size();
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	fsfl_stim_if   pins_ch();
	fsfl_result_if q_ch();

	q_level_board board;
	cfg_t         cell_cfg;
	level_t       pin_clock = LV_X;
	bit           tx_idle_on = 1'b1;
	bit           rx_idle_on = 1'b1;
	bit           hold_req = 1'b0;
	int           n_settings = 0;
	int           stall_cycles;

	four_state_flop_latch_eval dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.stim    (pins_ch),
		.result  (q_ch)
	);

	always #1 clk = ~clk;

	function automatic stim_t pins(level_t d, level_t c, level_t e, level_t r, level_t s);
		return '{data_level: d, clock_level: c, enable_level: e, clear_level: r, set_level: s};
	endfunction

	function automatic level_t rand_level(int pct_known);
		if ($urandom_range(0, 99) < pct_known)
			return level_t'($urandom_range(0, 1));
		return level_t'($urandom_range(2, 3));
	endfunction

	function automatic stim_t random_pins(bit well_formed);
		stim_t  s;
		level_t idle_clear;
		if (!well_formed) begin
			s = 10'($urandom);
			pin_clock = s.clock_level;
			return s;
		end
		if ($urandom_range(0, 99) < 60)
			pin_clock = (pin_clock == LV_ONE) ? LV_ZERO : LV_ONE;
		else if ($urandom_range(0, 99) < 8)
			pin_clock = level_t'($urandom_range(2, 3));
		idle_clear = (cell_cfg.clear_mode == CLR_ACT_LOW) ? LV_ONE : LV_ZERO;
		s.data_level   = rand_level(90);
		s.clock_level  = pin_clock;
		s.enable_level = ($urandom_range(0, 99) < 75) ? LV_ONE : level_t'($urandom_range(0, 3));
		s.clear_level  = ($urandom_range(0, 99) < 85) ? idle_clear : level_t'($urandom_range(0, 3));
		s.set_level    = ($urandom_range(0, 99) < 85) ? LV_ZERO : level_t'($urandom_range(0, 3));
		return s;
	endfunction

	task automatic program_cell(cfg_t c);
		reg_idx_t          idx;
		logic [DATA_W-1:0] val;
		for (int i = 0; i <= REG_HAS_SET; i++) begin
			idx = reg_idx_t'(i);
			case (idx)
				REG_IS_FLIP_FLOP: val = DATA_W'(c.is_flip_flop);
				REG_ASYNC_CLEAR:  val = DATA_W'(c.async_clear);
				REG_FALLING_EDGE: val = DATA_W'(c.falling_edge);
				REG_HAS_ENABLE:   val = DATA_W'(c.has_enable);
				REG_CLEAR_MODE:   val = DATA_W'(c.clear_mode);
				default:          val = DATA_W'(c.has_set);
			endcase
			if (i == 0) begin
				psel <= 1'b1;
				pwrite <= 1'b1;
			end
			penable <= 1'b0;
			paddr <= ADDR_W'({idx, 2'b00});
			pwdata <= val;
			@(posedge clk);
			penable <= 1'b1;
			do @(posedge clk); while (!pready);
			board.set_reg(idx, val);
		end
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		cell_cfg = c;
		n_settings++;
	endtask

	task automatic send_pins(stim_t s);
		pins_ch.valid <= 1'b1;
		pins_ch.data_level <= s.data_level;
		pins_ch.clock_level <= s.clock_level;
		pins_ch.enable_level <= s.enable_level;
		pins_ch.clear_level <= s.clear_level;
		pins_ch.set_level <= s.set_level;
		do @(posedge clk); while (!pins_ch.ready);
		board.note_pins(s);
	endtask

	task automatic rest_after_item(bit drain);
		bit gap;
		gap = drain || (tx_idle_on && $urandom_range(0, 99) < 32);
		if (gap) begin
			pins_ch.valid <= 1'b0;
			if (drain)
				do @(posedge clk); while (board.pending() != 0);
			else
				do @(posedge clk); while (tx_idle_on && $urandom_range(0, 99) < 32);
		end
	endtask

	task automatic play(stim_t seq[$]);
		foreach (seq[i]) begin
			send_pins(seq[i]);
			rest_after_item(i == seq.size() - 1);
		end
	endtask

	initial begin
		int hold_left;
		hold_left = 0;
		q_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (q_ch.valid && q_ch.ready)
				board.check_q(q_ch.q_level);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				q_ch.ready <= 1'b0;
			end else begin
				q_ch.ready <= rx_idle_on ? ($urandom_range(0, 99) >= 32) : 1'b1;
			end
		end
	end

	initial begin
		stall_cycles = 0;
		while (stall_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((pins_ch.valid && pins_ch.ready) || (q_ch.valid && q_ch.ready) || psel)
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		cfg_t  next_cfg;
		cfg_t  fixed_cfg[4];
		stim_t seq[$];
		board = new();
		cell_cfg = board.cur_cfg;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		pins_ch.valid <= 1'b0;
		pins_ch.data_level <= LV_ZERO;
		pins_ch.clock_level <= LV_ZERO;
		pins_ch.enable_level <= LV_ZERO;
		pins_ch.clear_level <= LV_ZERO;
		pins_ch.set_level <= LV_ZERO;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: rising-edge flop, no enable, clear or set
		seq = '{pins(LV_ONE, LV_ZERO, LV_ZERO, LV_ZERO, LV_ZERO),
			pins(LV_ONE, LV_ONE, LV_ZERO, LV_ZERO, LV_ZERO),
			pins(LV_ZERO, LV_ONE, LV_ZERO, LV_ZERO, LV_ZERO),
			pins(LV_ZERO, LV_ZERO, LV_ZERO, LV_ZERO, LV_ZERO),
			pins(PIN_Z, LV_ONE, LV_ZERO, LV_ZERO, LV_ZERO),
			pins(LV_ZERO, LV_X, LV_ZERO, LV_ZERO, LV_ZERO),
			pins(LV_ZERO, LV_ONE, LV_ZERO, LV_ZERO, LV_ZERO),
			pins(LV_ZERO, LV_ZERO, LV_ZERO, LV_ZERO, LV_ZERO),
			pins(LV_ZERO, LV_ONE, LV_ZERO, LV_ZERO, LV_ZERO),
			pins(LV_ONE, LV_ZERO, LV_ZERO, PIN_Z, PIN_Z),
			pins(LV_ONE, LV_ONE, LV_ZERO, PIN_Z, PIN_Z)};
		play(seq);

		// latch with active-high clear and set
		program_cell('{is_flip_flop: 1'b0, async_clear: 1'b0, falling_edge: 1'b0,
			has_enable: 1'b0, clear_mode: CLR_ACT_HIGH, has_set: 1'b1});
		seq = '{pins(LV_ONE, LV_ONE, LV_ZERO, LV_ZERO, LV_ZERO),
			pins(PIN_Z, LV_ONE, LV_ZERO, LV_ZERO, LV_ZERO),
			pins(LV_ZERO, LV_ZERO, LV_ZERO, LV_ZERO, LV_ZERO),
			pins(LV_ZERO, LV_ONE, LV_ZERO, LV_ONE, LV_ONE),
			pins(LV_ZERO, LV_ZERO, LV_ZERO, LV_ZERO, LV_ONE),
			pins(LV_ZERO, LV_ZERO, LV_ZERO, LV_ZERO, LV_X),
			pins(LV_ONE, PIN_Z, LV_ZERO, LV_ZERO, LV_ZERO)};
		play(seq);

		// falling-edge flop with async active-low reset, set and enable
		program_cell('{is_flip_flop: 1'b1, async_clear: 1'b1, falling_edge: 1'b1,
			has_enable: 1'b1, clear_mode: CLR_ACT_LOW, has_set: 1'b1});
		seq = '{pins(LV_ONE, LV_ONE, LV_ONE, LV_ONE, LV_ZERO),
			pins(LV_ONE, LV_ZERO, LV_ONE, LV_ONE, LV_ZERO),
			pins(LV_ONE, LV_ZERO, LV_ONE, LV_ZERO, LV_ZERO),
			pins(LV_ZERO, LV_ONE, LV_ONE, LV_ONE, LV_ONE),
			pins(LV_ZERO, LV_ZERO, LV_ONE, LV_ONE, LV_ONE),
			pins(LV_ZERO, LV_ONE, LV_ZERO, LV_X, LV_ZERO),
			pins(LV_ONE, LV_ZERO, LV_ZERO, LV_ONE, LV_ZERO),
			pins(LV_ONE, LV_ONE, LV_ONE, LV_ONE, LV_ZERO),
			pins(LV_ONE, LV_ZERO, LV_X, LV_ONE, LV_ZERO)};
		play(seq);

		fixed_cfg[0] = '{is_flip_flop: 1'b0, async_clear: 1'b0, falling_edge: 1'b0,
			has_enable: 1'b0, clear_mode: CLR_NONE, has_set: 1'b0};
		fixed_cfg[1] = '{is_flip_flop: 1'b1, async_clear: 1'b1, falling_edge: 1'b1,
			has_enable: 1'b1, clear_mode: CLR_ACT_HIGH, has_set: 1'b1};
		fixed_cfg[2] = '{is_flip_flop: 1'b1, async_clear: 1'b0, falling_edge: 1'b0,
			has_enable: 1'b1, clear_mode: CLR_ACT_LOW, has_set: 1'b1};
		fixed_cfg[3] = '{is_flip_flop: 1'b1, async_clear: 1'b1, falling_edge: 1'b0,
			has_enable: 1'b0, clear_mode: CLR_UNUSED, has_set: 1'b1};

		for (int p = 0; p < NUM_PHASES; p++) begin
			if (p < 4) begin
				next_cfg = fixed_cfg[p];
			end else begin
				next_cfg.is_flip_flop = ($urandom_range(0, 3) != 0);
				next_cfg.async_clear  = 1'($urandom_range(0, 1));
				next_cfg.falling_edge = 1'($urandom_range(0, 1));
				next_cfg.has_enable   = 1'($urandom_range(0, 1));
				next_cfg.clear_mode   = clr_mode_t'($urandom_range(CLR_NONE, CLR_ACT_HIGH));
				next_cfg.has_set      = 1'($urandom_range(0, 1));
			end
			program_cell(next_cfg);
			tx_idle_on = (p != 2);
			rx_idle_on = (p != 2);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if (p == 5 && k == 10)
					hold_req = 1'b1;
				send_pins(random_pins($urandom_range(0, 99) < 80));
				rest_after_item(k == PHASE_ITEMS - 1 || (p == 7 && k == 30));
			end
		end

		repeat (10) @(posedge clk);
		$display("Summary: %0d items over %0d cell settings, %0d results checked, %0d mismatches",
			board.n_items, n_settings, board.n_checked, board.n_errors);
		$display("Covered latch and flop, both edges, sync/async clear, set, enable, X/Z pins");
		if (board.n_errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/fsfl_pkg.sv
hdl/fsfl_stim_if.sv
hdl/fsfl_result_if.sv
hdl/fsfl_cfg_regs.sv
hdl/fsfl_next_q.sv
hdl/four_state_flop_latch_eval.sv
bench/tb_four_state_flop_latch_eval.sv
